// File: rtl/mtts_pkg.sv
// Shared types and constants of the move-toward-target step unit.
`timescale 1ns / 1ps

package mtts_pkg;

  // Fixed field widths of the beat formats and the register file.
  localparam int GOAL_W     = 12;
  localparam int TICKS_W    = 16;
  localparam int SPEED_W    = 24;
  localparam int SPEED_FRAC = 16;
  localparam int LIMIT_W    = 12;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Input tdata is goal_x, goal_y and ticks, padded to whole bytes.
  localparam int IN_TD_W = ((2 * GOAL_W + TICKS_W + 7) / 8) * 8;

  // Reset values of the registers.
  localparam logic [SPEED_W-1:0] SPEED_RESET = 24'h01_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'hFFF;

  // Register indexes on the write port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED   = 2'd0,
    REG_LIMIT_X = 2'd1,
    REG_LIMIT_Y = 2'd2
  } cfg_reg_t;

  // Item kinds carried in tuser.
  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SQ_GO   = 7'b0000010,
    ST_SQ_WAIT = 7'b0000100,
    ST_RT_WAIT = 7'b0001000,
    ST_MV_WAIT = 7'b0010000,
    ST_DV_WAIT = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

endpackage

// File: rtl/mtts_mul.sv
// Radix-2 shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module mtts_mul #(
  parameter int A_W = 8,
  parameter int B_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [A_W-1:0]   a_r, a_nxt;
  logic [A_W-1:0]   hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic [A_W:0]     sum;

  // Add the multiplicand when the bit leaving the low half is set.
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  // The product shifts right; multiplier bits leave at the bottom.
  always_comb begin
    cnt_nxt = cnt_r;
    a_nxt   = a_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    if (start) begin
      cnt_nxt = CNT_W'(B_W);
      a_nxt   = a;
      hi_nxt  = '0;
      lo_nxt  = b;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      hi_nxt  = sum[A_W:1];
      lo_nxt  = {sum[0], lo_r[B_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign busy = (cnt_r != '0);
  assign prod = {hi_r, lo_r};

endmodule

// File: rtl/mtts_sqrt.sv
// Restoring square root, one root bit (two radicand bits) per cycle.
`timescale 1ns / 1ps

module mtts_sqrt #(
  parameter int ROOT_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic                  busy,
  output logic [ROOT_W-1:0]     root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  // Bring down the next bit pair and try the root with a one appended.
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_comb begin
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      cnt_nxt  = CNT_W'(ROOT_W);
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = (cnt_r != '0);
  assign root = root_r;

endmodule

// File: rtl/mtts_div.sv
// Restoring divider, one quotient bit per cycle; the quotient must fit Q_W bits.
`timescale 1ns / 1ps

module mtts_div #(
  parameter int Q_W = 8,
  parameter int D_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [Q_W+D_W-1:0] num,
  input  logic [D_W-1:0]     den,
  output logic               busy,
  output logic [Q_W-1:0]     quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   den_r, den_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [D_W:0]     t;
  logic [D_W:0]     diff;
  logic             ge;

  // The low dividend bits leave the top of q_r as quotient bits enter below.
  assign t    = {rem_r, q_r[Q_W-1]};
  assign diff = t - {1'b0, den_r};
  assign ge   = (t >= {1'b0, den_r});

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt   = q_r;
    if (start) begin
      cnt_nxt = CNT_W'(Q_W);
      rem_nxt = num[Q_W+D_W-1:Q_W];
      den_nxt = den;
      q_nxt   = num[Q_W-1:0];
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[D_W-1:0] : t[D_W-1:0];
      q_nxt   = {q_r[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

endmodule

// File: rtl/move_toward_target_step_unit.sv
// Top level: target store, position update sequencer and result register.
//
//   Channel | Direction | Beat contents
//   in_     | slave     | tuser: mode; tdata: goal_x, goal_y, ticks
//   out_    | master    | tdata: pos_x, pos_y, at_target
//   cfg_    | write     | index 0 speed, 1 limit_x, 2 limit_y
//
// One item is worked on at a time. A set-target beat or a tick already in the target
// pixel goes from idle through the final state into the result register. A tick that
// snaps to the target runs the radix-2 squaring and root passes; a partial move then
// also runs the multiply and divide passes. Reset is synchronous and clears the control
// state. A stalled result holds the sequencer in its final state until it is taken.
`timescale 1ns / 1ps

module move_toward_target_step_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input beats
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [mtts_pkg::IN_TD_W-1:0]          in_tdata,  // goal_x, goal_y, ticks
  input  logic                                  in_tuser,  // mode
  // Result beats
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((2*(COORD_BITS+FRAC_BITS)+8)/8)*8-1:0] out_tdata, // pos_x, pos_y, at_target
  // Register writes
  input  logic                                  cfg_we,
  input  logic [mtts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mtts_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int POS_W    = COORD_BITS + FRAC_BITS;
  localparam int OUT_TD_W = ((2 * POS_W + 8) / 8) * 8;
  localparam int SH_L     = (FRAC_BITS >= mtts_pkg::SPEED_FRAC) ?
                            FRAC_BITS - mtts_pkg::SPEED_FRAC : 0;
  localparam int SH_R     = (FRAC_BITS < mtts_pkg::SPEED_FRAC) ?
                            mtts_pkg::SPEED_FRAC - FRAC_BITS : 0;
  localparam int PROD_S_W = mtts_pkg::SPEED_W + mtts_pkg::TICKS_W;
  localparam int STEP_W   = PROD_S_W + SH_L;

  mtts_pkg::state_t state_r, state_nxt;

  logic [mtts_pkg::SPEED_W-1:0] speed_r;
  logic [COORD_BITS-1:0]        limit_x_r, limit_y_r;
  logic [COORD_BITS-1:0]        aim_x_r, aim_x_nxt, aim_y_r, aim_y_nxt;
  logic [POS_W-1:0]             cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [POS_W-1:0]             mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic                         dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic [mtts_pkg::TICKS_W-1:0] ticks_r, ticks_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]             out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                         out_at_r, out_at_nxt;

  logic                         in_acc;
  logic                         out_acc;
  logic                         in_target;
  logic [COORD_BITS-1:0]        goal_x, goal_y;
  logic [POS_W-1:0]             ax, ay;
  logic [POS_W-1:0]             top_x, top_y;
  logic [STEP_W-1:0]            step_val;
  logic [2*POS_W+1:0]           sq_sum;
  logic [POS_W:0]               nx_raw, ny_raw;

  // Unit handshakes
  logic                         lane_start, step_start, sqrt_start, div_start;
  logic                         mul_x_busy, mul_y_busy, mul_s_busy;
  logic                         sqrt_busy, div_x_busy, div_y_busy;
  logic [POS_W:0]               lane_b_x, lane_b_y;
  logic [2*POS_W:0]             prod_x, prod_y;
  logic [PROD_S_W-1:0]          prod_s;
  logic [POS_W:0]               dist_root;
  logic [POS_W-1:0]             quo_x, quo_y;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Goals arrive as 12-bit pixels and are fitted to the coordinate width.
  assign goal_x = COORD_BITS'(in_tdata[mtts_pkg::GOAL_W-1:0]);
  assign goal_y = COORD_BITS'(in_tdata[2*mtts_pkg::GOAL_W-1:mtts_pkg::GOAL_W]);

  // Target and screen edge in position format.
  assign ax    = {aim_x_r, {FRAC_BITS{1'b0}}};
  assign ay    = {aim_y_r, {FRAC_BITS{1'b0}}};
  assign top_x = {limit_x_r, {FRAC_BITS{1'b0}}};
  assign top_y = {limit_y_r, {FRAC_BITS{1'b0}}};

  assign in_target = (cur_x_r[POS_W-1:FRAC_BITS] == aim_x_r) &&
                     (cur_y_r[POS_W-1:FRAC_BITS] == aim_y_r);

  // Step length rescaled from the speed format to the position format.
  assign step_val = (STEP_W'(prod_s) << SH_L) >> SH_R;

  // Squared distance, one bit wider than either square.
  assign sq_sum = (2*POS_W+2)'(prod_x) + (2*POS_W+2)'(prod_y);

  // Lane multipliers square the magnitudes first, then scale them by the step.
  assign lane_b_x = (state_r == mtts_pkg::ST_SQ_GO) ? {1'b0, mag_x_r} : step_r[POS_W:0];
  assign lane_b_y = (state_r == mtts_pkg::ST_SQ_GO) ? {1'b0, mag_y_r} : step_r[POS_W:0];

  // Partial move toward the target along each axis.
  assign nx_raw = dir_x_r ? {1'b0, cur_x_r} + {1'b0, quo_x} : {1'b0, cur_x_r} - {1'b0, quo_x};
  assign ny_raw = dir_y_r ? {1'b0, cur_y_r} + {1'b0, quo_y} : {1'b0, cur_y_r} - {1'b0, quo_y};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    aim_x_nxt     = aim_x_r;
    aim_y_nxt     = aim_y_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    mag_x_nxt     = mag_x_r;
    mag_y_nxt     = mag_y_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    ticks_nxt     = ticks_r;
    step_nxt      = step_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_at_nxt    = out_at_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    lane_start    = 1'b0;
    step_start    = 1'b0;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      mtts_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == mtts_pkg::MODE_SET) begin
            aim_x_nxt = (goal_x > limit_x_r) ? limit_x_r : goal_x;
            aim_y_nxt = (goal_y > limit_y_r) ? limit_y_r : goal_y;
            state_nxt = mtts_pkg::ST_FIN;
          end else begin
            ticks_nxt = in_tdata[2*mtts_pkg::GOAL_W +: mtts_pkg::TICKS_W];
            dir_x_nxt = (ax >= cur_x_r);
            dir_y_nxt = (ay >= cur_y_r);
            mag_x_nxt = (ax >= cur_x_r) ? ax - cur_x_r : cur_x_r - ax;
            mag_y_nxt = (ay >= cur_y_r) ? ay - cur_y_r : cur_y_r - ay;
            state_nxt = in_target ? mtts_pkg::ST_FIN : mtts_pkg::ST_SQ_GO;
          end
        end
      end
      mtts_pkg::ST_SQ_GO: begin
        lane_start = 1'b1;
        step_start = 1'b1;
        state_nxt  = mtts_pkg::ST_SQ_WAIT;
      end
      mtts_pkg::ST_SQ_WAIT: begin
        if (!(mul_x_busy || mul_y_busy || mul_s_busy)) begin
          sqrt_start = 1'b1;
          step_nxt   = step_val;
          state_nxt  = mtts_pkg::ST_RT_WAIT;
        end
      end
      mtts_pkg::ST_RT_WAIT: begin
        if (!sqrt_busy) begin
          if (step_r >= STEP_W'(dist_root)) begin
            // The step reaches the target: snap onto it.
            cur_x_nxt = ax;
            cur_y_nxt = ay;
            state_nxt = mtts_pkg::ST_FIN;
          end else begin
            lane_start = 1'b1;
            state_nxt  = mtts_pkg::ST_MV_WAIT;
          end
        end
      end
      mtts_pkg::ST_MV_WAIT: begin
        if (!(mul_x_busy || mul_y_busy)) begin
          div_start = 1'b1;
          state_nxt = mtts_pkg::ST_DV_WAIT;
        end
      end
      mtts_pkg::ST_DV_WAIT: begin
        if (!(div_x_busy || div_y_busy)) begin
          cur_x_nxt = (nx_raw > {1'b0, top_x}) ? top_x : nx_raw[POS_W-1:0];
          cur_y_nxt = (ny_raw > {1'b0, top_y}) ? top_y : ny_raw[POS_W-1:0];
          state_nxt = mtts_pkg::ST_FIN;
        end
      end
      mtts_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_x_nxt     = cur_x_r;
          out_y_nxt     = cur_y_r;
          out_at_nxt    = in_target;
          out_valid_nxt = 1'b1;
          state_nxt     = mtts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtts_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      aim_x_r     <= '0;
      aim_y_r     <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      aim_x_r     <= aim_x_nxt;
      aim_y_r     <= aim_y_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
    end
  end

  // Register writes; limits keep the low 12 bits fitted to the coordinate width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= mtts_pkg::SPEED_RESET;
      limit_x_r <= COORD_BITS'(mtts_pkg::LIMIT_RESET);
      limit_y_r <= COORD_BITS'(mtts_pkg::LIMIT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtts_pkg::REG_SPEED:   speed_r   <= cfg_wdata[mtts_pkg::SPEED_W-1:0];
        mtts_pkg::REG_LIMIT_X: limit_x_r <= COORD_BITS'(cfg_wdata[mtts_pkg::LIMIT_W-1:0]);
        mtts_pkg::REG_LIMIT_Y: limit_y_r <= COORD_BITS'(cfg_wdata[mtts_pkg::LIMIT_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    mag_x_r  <= mag_x_nxt;
    mag_y_r  <= mag_y_nxt;
    dir_x_r  <= dir_x_nxt;
    dir_y_r  <= dir_y_nxt;
    ticks_r  <= ticks_nxt;
    step_r   <= step_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_at_r <= out_at_nxt;
  end

  // Arithmetic units
  mtts_mul #(.A_W(POS_W), .B_W(POS_W + 1)) u_mul_x (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .a(mag_x_r), .b(lane_b_x), .busy(mul_x_busy), .prod(prod_x)
  );

  mtts_mul #(.A_W(POS_W), .B_W(POS_W + 1)) u_mul_y (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .a(mag_y_r), .b(lane_b_y), .busy(mul_y_busy), .prod(prod_y)
  );

  mtts_mul #(.A_W(mtts_pkg::SPEED_W), .B_W(mtts_pkg::TICKS_W)) u_mul_step (
    .clk(clk), .rst_n(rst_n), .start(step_start),
    .a(speed_r), .b(ticks_r), .busy(mul_s_busy), .prod(prod_s)
  );

  mtts_sqrt #(.ROOT_W(POS_W + 1)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start),
    .rad(sq_sum), .busy(sqrt_busy), .root(dist_root)
  );

  mtts_div #(.Q_W(POS_W), .D_W(POS_W + 1)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(prod_x), .den(dist_root), .busy(div_x_busy), .quo(quo_x)
  );

  mtts_div #(.Q_W(POS_W), .D_W(POS_W + 1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(prod_y), .den(dist_root), .busy(div_y_busy), .quo(quo_y)
  );

  // Ports
  assign in_tready  = (state_r == mtts_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'({out_at_r, out_y_r, out_x_r});

  // The two axis lanes always run in step.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_x_busy == mul_y_busy) && (div_x_busy == div_y_busy))
    else $error("axis lanes out of step");

  // An axis never moves further than its distance to the target.
  a_move_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtts_pkg::ST_DV_WAIT && !div_x_busy && !div_y_busy) |->
    (quo_x <= mag_x_r) && (quo_y <= mag_y_r))
    else $error("axis move exceeds distance to target");

  // A stored target lies within the limits that were set when it was taken.
  a_aim_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == mtts_pkg::MODE_SET) |=>
    (aim_x_r <= limit_x_r) && (aim_y_r <= limit_y_r))
    else $error("target stored beyond limit");

  // An accepted beat leads either to the result stage or into the squaring pass.
  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == mtts_pkg::ST_FIN) || (state_r == mtts_pkg::ST_SQ_GO))
    else $error("unexpected state after accepted beat");

endmodule

// File: tb/tb_move_toward_target_step_unit.sv
// Self-checking testbench for the move-toward-target step unit.
`timescale 1ns / 1ps

module tb_move_toward_target_step_unit;

  localparam int COORD    = 12;
  localparam int FRAC     = 16;
  localparam int POS_W    = COORD + FRAC;
  localparam int OUT_TD_W = ((2 * POS_W + 8) / 8) * 8;
  localparam int DIR_ROWS = 36;
  localparam int BLOCKS   = 6;
  localparam int BLOCK_ITEMS = 70;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 130;
  localparam int GW = mtts_pkg::GOAL_W;
  localparam int TW = mtts_pkg::TICKS_W;
  localparam int SW = mtts_pkg::SPEED_W;
  localparam int LW = mtts_pkg::LIMIT_W;
  localparam int DW = mtts_pkg::CFG_DATA_W;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an input beat or a register write.
  typedef struct packed {
    row_kind_t           kind;
    logic                mode;
    logic [GW-1:0]       gx;
    logic [GW-1:0]       gy;
    logic [TW-1:0]       tk;
    mtts_pkg::cfg_reg_t  reg_idx;
    logic [SW-1:0]       reg_val;
    logic                fixed_exp;
    logic [POS_W-1:0]    ex;
    logic [POS_W-1:0]    ey;
    logic                eat;
  } stim_row_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             at;
  } pos_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [mtts_pkg::IN_TD_W-1:0]      in_tdata = '0;   // goal_x, goal_y, ticks
  logic                              in_tuser = 1'b0; // mode
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [OUT_TD_W-1:0]               out_tdata;       // pos_x, pos_y, at_target
  logic                              cfg_we = 1'b0;
  logic [mtts_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [DW-1:0]                     cfg_wdata = '0;

  // Predicted state of the block and its registers.
  logic [POS_W-1:0] cur_x, cur_y;
  logic [GW-1:0]    aim_x, aim_y;
  logic [SW-1:0]    speed_r;
  logic [LW-1:0]    lim_x, lim_y;

  pos_result_t pending_pos[$];
  stim_row_t   dir_tab[DIR_ROWS];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 36;
  int          recv_idle_pct = 57;

  move_toward_target_step_unit #(
    .COORD_BITS(COORD),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Table row builders.
  function automatic stim_row_t put(logic mode, logic [GW-1:0] gx,
                                    logic [GW-1:0] gy, logic [TW-1:0] tk);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mode = mode;
    r.gx = gx;
    r.gy = gy;
    r.tk = tk;
    return r;
  endfunction

  function automatic stim_row_t put_chk(logic mode, logic [GW-1:0] gx,
                                        logic [GW-1:0] gy, logic [TW-1:0] tk,
                                        logic [POS_W-1:0] ex, logic [POS_W-1:0] ey,
                                        logic eat);
    stim_row_t r;
    r = put(mode, gx, gy, tk);
    r.fixed_exp = 1'b1;
    r.ex = ex;
    r.ey = ey;
    r.eat = eat;
    return r;
  endfunction

  function automatic stim_row_t set_reg(mtts_pkg::cfg_reg_t idx, logic [SW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Truncating square root, one result bit per pass.
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic on_aim();
    return cur_x[POS_W-1:FRAC] == aim_x && cur_y[POS_W-1:FRAC] == aim_y;
  endfunction

  // Partial move along one axis, then clamped to the screen limit.
  function automatic logic [POS_W-1:0] axis_step(logic [63:0] cur, logic [63:0] aimp,
                                                 logic [63:0] mag, logic [63:0] step,
                                                 logic [63:0] span, logic [LW-1:0] lim);
    logic [63:0] m, n, top;
    m = (mag * step) / span;
    n = (aimp >= cur) ? cur + m : cur - m;
    top = 64'(lim) << FRAC;
    if (n > top) n = top;
    return n[POS_W-1:0];
  endfunction

  // Works out the result of one accepted beat and updates the predicted state.
  task automatic move_position(input logic mode, input logic [GW-1:0] gx,
                               input logic [GW-1:0] gy, input logic [TW-1:0] tk,
                               output pos_result_t r);
    logic [63:0] ax, ay, mx, my, span, step;
    if (mode == mtts_pkg::MODE_SET) begin
      aim_x = (gx > lim_x) ? lim_x : gx;
      aim_y = (gy > lim_y) ? lim_y : gy;
    end else if (!on_aim()) begin
      ax = 64'(aim_x) << FRAC;
      ay = 64'(aim_y) << FRAC;
      mx = (ax >= 64'(cur_x)) ? ax - 64'(cur_x) : 64'(cur_x) - ax;
      my = (ay >= 64'(cur_y)) ? ay - 64'(cur_y) : 64'(cur_y) - ay;
      span = root64(mx * mx + my * my);
      step = 64'(tk) * 64'(speed_r);
      if (step >= span) begin
        // The step reaches the target, so the position snaps onto it.
        cur_x = ax[POS_W-1:0];
        cur_y = ay[POS_W-1:0];
      end else begin
        cur_x = axis_step(64'(cur_x), ax, mx, step, span, lim_x);
        cur_y = axis_step(64'(cur_y), ay, my, step, span, lim_y);
      end
    end
    r.x = cur_x;
    r.y = cur_y;
    r.at = on_aim();
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    fail_cnt++;
  endtask

  // Holds the input back until every predicted result has been taken.
  task automatic settle_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input mtts_pkg::cfg_reg_t idx, input logic [DW-1:0] val);
    settle_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      mtts_pkg::REG_SPEED:   speed_r = val[SW-1:0];
      mtts_pkg::REG_LIMIT_X: lim_x = val[LW-1:0];
      mtts_pkg::REG_LIMIT_Y: lim_y = val[LW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Presents one beat, waits for it to be taken and queues its result.
  task automatic send_row(input stim_row_t row);
    pos_result_t pred;
    pos_result_t fixed_res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = row.mode;
    in_tdata = {row.tk, row.gy, row.gx};
    do @(posedge clk); while (in_tready !== 1'b1);
    move_position(row.mode, row.gx, row.gy, row.tk, pred);
    if (row.fixed_exp) begin
      fixed_res.x = row.ex;
      fixed_res.y = row.ey;
      fixed_res.at = row.eat;
      pending_pos.push_back(fixed_res);
    end else begin
      pending_pos.push_back(pred);
    end
  endtask

  task automatic random_config();
    logic [SW-1:0] spd;
    logic [LW-1:0] lx, ly;
    case ($urandom_range(7))
      0: spd = '0;
      1: spd = '1;
      2: spd = SW'($urandom_range(1, 255));
      3: spd = SW'($urandom);
      default: spd = SW'($urandom_range(2048, 24'h06_0000));
    endcase
    case ($urandom_range(5))
      0: lx = '0;
      1, 2: lx = mtts_pkg::LIMIT_RESET;
      3: lx = LW'($urandom_range(1, 63));
      default: lx = LW'($urandom_range(4095));
    endcase
    case ($urandom_range(5))
      0: ly = '0;
      1, 2: ly = mtts_pkg::LIMIT_RESET;
      3: ly = LW'($urandom_range(1, 63));
      default: ly = LW'($urandom_range(4095));
    endcase
    write_reg(mtts_pkg::REG_SPEED, DW'(spd));
    write_reg(mtts_pkg::REG_LIMIT_X, DW'(lx));
    write_reg(mtts_pkg::REG_LIMIT_Y, DW'(ly));
  endtask

  // Mostly a new target followed by runs of ticks, with noise in unused fields.
  task automatic random_item(output stim_row_t row);
    logic [TW-1:0] tk;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: tk = TW'($urandom_range(0, 8));
      7, 8: tk = TW'($urandom_range(0, 300));
      default: tk = TW'($urandom);
    endcase
    if ($urandom_range(3) == 0)
      row = put(mtts_pkg::MODE_SET, GW'($urandom), GW'($urandom), tk);
    else
      row = put(mtts_pkg::MODE_TICK, GW'($urandom), GW'($urandom), tk);
  endtask

  // Receiver side: random back-pressure on the result channel.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: each result beat against the oldest prediction.
  always @(posedge clk) begin
    pos_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pos.size() == 0) begin
        flag_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want = pending_pos.pop_front();
        if (out_tdata[POS_W-1:0] !== want.x)
          flag_mismatch("pos_x", 64'(out_tdata[POS_W-1:0]), 64'(want.x));
        if (out_tdata[2*POS_W-1:POS_W] !== want.y)
          flag_mismatch("pos_y", 64'(out_tdata[2*POS_W-1:POS_W]), 64'(want.y));
        if (out_tdata[2*POS_W] !== want.at)
          flag_mismatch("at_target", 64'(out_tdata[2*POS_W]), 64'(want.at));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int drain;
    speed_r = mtts_pkg::SPEED_RESET;
    lim_x = mtts_pkg::LIMIT_RESET;
    lim_y = mtts_pkg::LIMIT_RESET;
    cur_x = '0;
    cur_y = '0;
    aim_x = '0;
    aim_y = '0;

    dir_tab = '{
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd5, 28'h0, 28'h0, 1'b1),
      put_chk(mtts_pkg::MODE_SET, 12'd4095, 12'd4095, 16'hFFFF, 28'h0, 28'h0, 1'b0),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd0, 28'h0, 28'h0, 1'b0),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'hFFFF, 28'hFFF0000, 28'hFFF0000, 1'b1),
      put_chk(mtts_pkg::MODE_SET, 12'd0, 12'd0, 16'd0, 28'hFFF0000, 28'hFFF0000, 1'b0),
      put(mtts_pkg::MODE_TICK, 12'd4095, 12'd4095, 16'd1),
      set_reg(mtts_pkg::REG_SPEED, 24'hFF_FFFF),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'hFFFF, 28'h0, 28'h0, 1'b1),
      set_reg(mtts_pkg::REG_SPEED, 24'h0),
      put_chk(mtts_pkg::MODE_SET, 12'd3000, 12'd17, 16'd0, 28'h0, 28'h0, 1'b0),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd40000, 28'h0, 28'h0, 1'b0),
      set_reg(mtts_pkg::REG_SPEED, 24'h04_8000),
      put_chk(mtts_pkg::MODE_SET, 12'd5, 12'd0, 16'd0, 28'h0, 28'h0, 1'b0),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd1, 28'h48000, 28'h0, 1'b0),
      put_chk(mtts_pkg::MODE_SET, 12'd4, 12'd0, 16'd0, 28'h48000, 28'h0, 1'b1),
      put_chk(mtts_pkg::MODE_TICK, 12'd2730, 12'd1365, 16'd3, 28'h48000, 28'h0, 1'b1),
      set_reg(mtts_pkg::REG_SPEED, 24'hFF_FFFF),
      put_chk(mtts_pkg::MODE_SET, 12'd4000, 12'd4000, 16'd0, 28'h48000, 28'h0, 1'b0),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'hFFFF, 28'hFA00000, 28'hFA00000, 1'b1),
      put_chk(mtts_pkg::MODE_SET, 12'd4095, 12'd4095, 16'd0, 28'hFA00000, 28'hFA00000, 1'b0),
      set_reg(mtts_pkg::REG_LIMIT_X, 24'd100),
      set_reg(mtts_pkg::REG_LIMIT_Y, 24'd200),
      set_reg(mtts_pkg::REG_SPEED, 24'h01_0000),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd1, 28'h640000, 28'hC80000, 1'b0),
      put_chk(mtts_pkg::MODE_SET, 12'd4095, 12'd4095, 16'd0, 28'h640000, 28'hC80000, 1'b1),
      set_reg(mtts_pkg::REG_LIMIT_X, 24'd0),
      set_reg(mtts_pkg::REG_LIMIT_Y, 24'd0),
      put_chk(mtts_pkg::MODE_SET, 12'd4095, 12'd4095, 16'd0, 28'h640000, 28'hC80000, 1'b0),
      put_chk(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'hFFFF, 28'h0, 28'h0, 1'b1),
      set_reg(mtts_pkg::REG_LIMIT_X, 24'hFFF),
      set_reg(mtts_pkg::REG_LIMIT_Y, 24'hFFF),
      set_reg(mtts_pkg::REG_SPEED, 24'h01_0000),
      put(mtts_pkg::MODE_SET, 12'd2047, 12'd1, 16'd0),
      put(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd7),
      put(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'd300),
      put(mtts_pkg::MODE_TICK, 12'd0, 12'd0, 16'hFFFF)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: reset state, field extremes and the special cases.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_reg(dir_tab[i].reg_idx, DW'(dir_tab[i].reg_val));
      else
        send_row(dir_tab[i]);
    end

    // Random blocks over three idling phases, each block with its own settings.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 36 : 0;
      for (int blk = 0; blk < BLOCKS; blk++) begin
        random_config();
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          random_item(row);
          if ($urandom_range(59) == 0) settle_results();
          send_row(row);
        end
      end
    end

    // Let the last results come out, within a bound.
    @(negedge clk);
    in_tvalid = 1'b0;
    drain = 0;
    while (pending_pos.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pos.size() != 0)
      flag_mismatch("missing results", 64'(pending_pos.size()), '0);

    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
